### hw/rtl/serial_loaded_bank_mapper_assert.svh
// Assertion macros for the serial loaded bank mapper checker.
// Needs signals named clk and rst in the scope that uses them.
`ifndef SERIAL_LOADED_BANK_MAPPER_ASSERT_SVH
`define SERIAL_LOADED_BANK_MAPPER_ASSERT_SVH

// Checked only outside reset.
`define SLBM_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked also while reset is held.
`define SLBM_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### hw/rtl/slbm_pkg.sv
// Shared types and constants for the serial loaded bank mapper.
// No dependencies; used by slbm_map and serial_loaded_bank_mapper.
package slbm_pkg;

  localparam int unsigned ADDR_W  = 16;
  localparam int unsigned DATA_W  = 8;
  localparam int unsigned MADDR_W = 19;
  localparam int unsigned PADDR_W = 4;

  localparam logic [ADDR_W-1:0] COMMON_TOP = 16'h4020;
  localparam logic [ADDR_W-1:0] RAM_BASE   = 16'h6000;
  localparam logic [ADDR_W-1:0] ROM_BASE   = 16'h8000;

  localparam logic [2:0] LOAD_BITS = 3'd5;

  localparam logic [1:0] PRG_FIX_FIRST = 2'd2;
  localparam logic [1:0] PRG_FIX_LAST  = 2'd3;

  typedef enum logic [1:0] {
    MODE_CPU_RD = 2'd0,
    MODE_CPU_WR = 2'd1,
    MODE_PPU_RD = 2'd2,
    MODE_PPU_WR = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    TGT_NONE    = 3'd0,
    TGT_COMMON  = 3'd1,
    TGT_PRG_RAM = 3'd2,
    TGT_PRG_ROM = 3'd3,
    TGT_CHR     = 3'd4
  } target_t;

  // Register picked by CPU address bits 14:13 on the fifth serial bit.
  typedef enum logic [1:0] {
    SEL_CONTROL = 2'd0,
    SEL_CHR0    = 2'd1,
    SEL_CHR1    = 2'd2,
    SEL_PRG     = 2'd3
  } load_sel_t;

  // Configuration register index (paddr[3:2]).
  typedef enum logic [1:0] {
    REG_PRG_RAM_PRESENT = 2'd0,
    REG_LAST_PRG_BANK   = 2'd1,
    REG_CHR_ROM_BANKS   = 2'd2,
    REG_CHR_BANK_MASK   = 2'd3
  } reg_index_t;

  typedef struct packed {
    logic       prg_ram_present;
    logic [4:0] last_prg_bank;
    logic [4:0] chr_rom_banks;
    logic [4:0] chr_bank_mask;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    prg_ram_present: 1'b1,
    last_prg_bank:   5'd7,
    chr_rom_banks:   5'd1,
    chr_bank_mask:   5'd31
  };

  typedef struct packed {
    logic [4:0] shift_value;
    logic [2:0] bit_count;
    logic [1:0] prg_bank_mode;
    logic       chr_bank_mode;
    logic [4:0] chr_low_bank;
    logic [4:0] chr_high_bank;
    logic [3:0] prg_bank;
    logic [1:0] mirror_mode;
  } bank_state_t;

  localparam bank_state_t STATE_RESET = '{
    shift_value:   5'd0,
    bit_count:     3'd0,
    prg_bank_mode: PRG_FIX_LAST,
    chr_bank_mode: 1'b0,
    chr_low_bank:  5'd0,
    chr_high_bank: 5'd0,
    prg_bank:      4'd0,
    mirror_mode:   2'd0
  };

  typedef struct packed {
    logic [DATA_W-1:0] write_data;
    logic [ADDR_W-1:0] address;
    mode_t             mode;
  } access_t;

  typedef struct packed {
    logic [1:0]         mirroring;
    logic               write_enable;
    logic [MADDR_W-1:0] mem_address;
    target_t            target;
  } result_t;

endpackage

### hw/rtl/slbm_map.sv
// Combinational address map and serial register update for one access.
// Depends on slbm_pkg.
module slbm_map (
  input  slbm_pkg::access_t     acc,
  input  slbm_pkg::cfg_t        cfg,
  input  slbm_pkg::bank_state_t st,
  output slbm_pkg::bank_state_t st_next,
  output slbm_pkg::result_t     res
);
  import slbm_pkg::*;

  logic [MADDR_W-1:0] prg_rom_addr;
  bank_state_t        load_next;
  logic [4:0]         shift_acc;
  logic [2:0]         count_inc;
  logic [12:0]        ppu_addr;
  logic [4:0]         chr_bank;
  logic [ADDR_W-1:0]  a;

  assign a        = acc.address;
  assign ppu_addr = acc.address[12:0];
  assign chr_bank = ppu_addr[12] ? st.chr_high_bank : st.chr_low_bank;

  // PRG ROM banking; a[14] marks the 0xC000 half here.
  always_comb begin
    if (!st.prg_bank_mode[1]) begin
      prg_rom_addr = {1'b0, st.prg_bank[3:1], a[14:0]};
    end else if (st.prg_bank_mode == PRG_FIX_FIRST) begin
      prg_rom_addr = a[14] ? {1'b0, st.prg_bank, a[13:0]} : {5'b0, a[13:0]};
    end else begin
      prg_rom_addr = a[14] ? {cfg.last_prg_bank, a[13:0]} : {1'b0, st.prg_bank, a[13:0]};
    end
  end

  // Serial load, LSB first.
  always_comb begin
    shift_acc = st.shift_value | (5'({4'b0, acc.write_data[0]}) << st.bit_count);
    count_inc = st.bit_count + 3'd1;
    load_next = st;
    if (acc.write_data[7]) begin
      load_next.shift_value   = '0;
      load_next.bit_count     = '0;
      load_next.prg_bank_mode = PRG_FIX_LAST;
    end else if (count_inc == LOAD_BITS) begin
      unique case (load_sel_t'(a[14:13]))
        SEL_CONTROL: begin
          load_next.mirror_mode   = shift_acc[1:0];
          load_next.prg_bank_mode = shift_acc[3:2];
          load_next.chr_bank_mode = shift_acc[4];
        end
        SEL_CHR0: load_next.chr_low_bank  = shift_acc;
        SEL_CHR1: load_next.chr_high_bank = shift_acc;
        SEL_PRG:  load_next.prg_bank      = shift_acc[3:0];
      endcase
      load_next.shift_value = '0;
      load_next.bit_count   = '0;
    end else begin
      load_next.shift_value = shift_acc;
      load_next.bit_count   = count_inc;
    end
  end

  always_comb begin
    st_next          = st;
    res.target       = TGT_NONE;
    res.mem_address  = '0;
    res.write_enable = 1'b0;
    unique case (acc.mode)
      MODE_CPU_RD, MODE_CPU_WR: begin
        if (a < COMMON_TOP) begin
          res.target       = TGT_COMMON;
          res.mem_address  = {3'b0, a};
          res.write_enable = (acc.mode == MODE_CPU_WR);
        end else if (a < RAM_BASE) begin
          res.target = TGT_NONE;
        end else if (a < ROM_BASE) begin
          if (cfg.prg_ram_present) begin
            res.target       = TGT_PRG_RAM;
            res.mem_address  = {6'b0, a[12:0]};
            res.write_enable = (acc.mode == MODE_CPU_WR);
          end
        end else if (acc.mode == MODE_CPU_WR) begin
          st_next = load_next;
        end else begin
          res.target      = TGT_PRG_ROM;
          res.mem_address = prg_rom_addr;
        end
      end
      MODE_PPU_RD: begin
        res.target = TGT_CHR;
        if (!st.chr_bank_mode) begin
          res.mem_address = (cfg.chr_rom_banks < 5'd2) ? {6'b0, ppu_addr}
                                                       : {2'b0, st.chr_low_bank[4:1], ppu_addr};
        end else begin
          res.mem_address = {2'b0, chr_bank & cfg.chr_bank_mask, ppu_addr[11:0]};
        end
      end
      MODE_PPU_WR: begin
        // CHR RAM only; writes to CHR ROM are dropped.
        if (cfg.chr_rom_banks == 5'd0) begin
          res.target       = TGT_CHR;
          res.write_enable = 1'b1;
          res.mem_address  = st.chr_bank_mode ? {6'b0, chr_bank[0], ppu_addr[11:0]}
                                              : {6'b0, ppu_addr};
        end
      end
    endcase
    res.mirroring = st_next.mirror_mode;
  end

endmodule

### hw/rtl/serial_loaded_bank_mapper.sv
// Top level of the serial loaded bank mapper: stream channels, APB config.
// Depends on slbm_pkg and slbm_map.
//
// Usage:
//   Slave stream takes one bus access per transfer: s_tuser = access mode,
//   s_tdata = address and write byte. Master stream returns one result per
//   access: target memory, byte address in it, write enable, mirroring.
//   Results come out in access order, exactly one per access.
// Path: input register, then result register (m_tvalid); the result transfer
//   can follow at the next edge. Throughput: one access per cycle while the
//   result stage drains (m_tready high or m_tvalid low); the map and the serial
//   register update are a single combinational pass between the two registers,
//   so back-to-back accesses see each other's bank updates.
// Stalls: while m_tready is low the result holds; the input register keeps
//   one more access, after which s_tready drops. No transfer is lost.
// Reset (rst, synchronous): both stages empty, bank state back to PRG mode 3
//   with all banks 0, config registers back to their defaults.
// Config: APB writes at paddr 0/4/8/12, no wait states (pready tied high).
//   Write only while no access is in flight.
module serial_loaded_bank_mapper (
  input  logic                          clk,
  input  logic                          rst,
  // s_tdata: [15:0] address, [23:16] write_data
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [23:0]                   s_tdata,
  // s_tuser: [1:0] mode
  input  logic [1:0]                    s_tuser,
  // m_tdata: [2:0] target, [21:3] mem_address, [22] write_enable,
  //          [24:23] mirroring, [31:25] zero
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [31:0]                   m_tdata,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [slbm_pkg::PADDR_W-1:0]  paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import slbm_pkg::*;

  cfg_t        cfg;
  bank_state_t st;
  bank_state_t st_next;
  access_t     in_acc;
  logic        in_valid;
  result_t     res;
  result_t     out_res;
  logic        out_free;
  logic        advance;
  logic        cfg_wr;
  reg_index_t  reg_idx;

  // ---- config port ----
  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite & pready;
  assign reg_idx = reg_index_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= CFG_RESET;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_PRG_RAM_PRESENT: cfg.prg_ram_present <= pwdata[0];
        REG_LAST_PRG_BANK:   cfg.last_prg_bank   <= pwdata[4:0];
        REG_CHR_ROM_BANKS:   cfg.chr_rom_banks   <= pwdata[4:0];
        REG_CHR_BANK_MASK:   cfg.chr_bank_mask   <= pwdata[4:0];
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_PRG_RAM_PRESENT: prdata = {31'b0, cfg.prg_ram_present};
      REG_LAST_PRG_BANK:   prdata = {27'b0, cfg.last_prg_bank};
      REG_CHR_ROM_BANKS:   prdata = {27'b0, cfg.chr_rom_banks};
      REG_CHR_BANK_MASK:   prdata = {27'b0, cfg.chr_bank_mask};
    endcase
  end

  // ---- handshake ----
  // The access in the input register moves on when the result register
  // is empty or being drained this cycle.
  assign out_free = !m_tvalid || m_tready;
  assign advance  = in_valid && out_free;
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_acc.mode       <= mode_t'(s_tuser);
      in_acc.address    <= s_tdata[15:0];
      in_acc.write_data <= s_tdata[23:16];
    end
  end

  // ---- map and bank state ----
  slbm_map u_map (
    .acc     (in_acc),
    .cfg     (cfg),
    .st      (st),
    .st_next (st_next),
    .res     (res)
  );

  // Bank state commits only when the access leaves the input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= STATE_RESET;
    end else if (advance) begin
      st <= st_next;
    end
  end

  // ---- result register ----
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_free) begin
      m_tvalid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res <= res;
    end
  end

  assign m_tdata = {7'b0, out_res};

endmodule

### hw/rtl/slbm_checker.sv
// Port-level checks for serial_loaded_bank_mapper, bound to the top level.
// Depends on serial_loaded_bank_mapper_assert.svh.
`include "serial_loaded_bank_mapper_assert.svh"

module slbm_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata
);

  // A stalled result holds.
  `SLBM_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "result changed while stalled")

  // Reset empties the result stage.
  `SLBM_ASSERT_RST(a_rst_empty, rst |=> !m_tvalid, "result valid right after reset")

  // No target means no address and no write.
  `SLBM_ASSERT(a_none_clear, m_tvalid && m_tdata[2:0] == 3'd0 |-> m_tdata[22:3] == 20'd0, "target none with address or write")

  // Writes land only on common bus, work RAM or CHR memory.
  `SLBM_ASSERT(a_we_target, m_tvalid && m_tdata[22] |-> m_tdata[2:0] == 3'd1 || m_tdata[2:0] == 3'd2 || m_tdata[2:0] == 3'd4, "write enable on a read-only target")

  // Common bus addresses stay below 64K.
  `SLBM_ASSERT(a_common_range, m_tvalid && m_tdata[2:0] == 3'd1 |-> m_tdata[21:19] == 3'd0, "common bus address out of range")

endmodule

bind serial_loaded_bank_mapper slbm_checker u_slbm_checker (.*);
